/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; expects clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define EECPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define EECPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/eecpc_pkg.sv */
// shared widths, codes and types for the edge pair closest point classifier
// no dependencies
package eecpc_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // datapath widths, derived from the coordinate width, the tolerance width and FRAC_BITS
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int LEN_W  = DOT_W - 1;
   localparam int BIG_W  = 2 * DOT_W;
   localparam int DEL_W  = BIG_W + 1;
   localparam int TOL_W  = 32;
   localparam int TA_W   = TOL_W + LEN_W;
   localparam int TA_LO  = (TA_W + 1) / 2;
   localparam int TA_HI  = TA_W - TA_LO;
   localparam int CMP_W  = TOL_W + DEL_W + 1;
   localparam int DIV_W  = DEL_W;
   localparam int OUT_W  = FRAC_BITS + 1;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
   localparam logic [OUT_W-1:0] PARAM_ONE = OUT_W'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      CLS_EE    = 4'd0,
      CLS_VE023 = 4'd1,
      CLS_VE123 = 4'd2,
      CLS_VV02  = 4'd3,
      CLS_VV12  = 4'd4,
      CLS_VE201 = 4'd5,
      CLS_VV03  = 4'd6,
      CLS_VV13  = 4'd7,
      CLS_VE301 = 4'd8
   } pair_class_type;

   typedef enum logic [1:0] {
      SEL_ZERO = 2'd0,
      SEL_ONE  = 2'd1,
      SEL_DIV  = 2'd2
   } param_sel_type;

   typedef struct packed {
      logic           valid;
      pair_class_type cls;
      param_sel_type  t0_sel;
      param_sel_type  t1_sel;
   } meta_type;

endpackage

/* sv/eecpc_div.sv */
// pipelined restoring fraction divider, one quotient bit per stage
// depends on eecpc_pkg
module eecpc_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [eecpc_pkg::DIV_W-1:0]     num_in,
   input  logic [eecpc_pkg::DIV_W-1:0]     den_in,
   output logic [eecpc_pkg::FRAC_BITS-1:0] quo_out
);
   import eecpc_pkg::*;

   logic [DIV_W-1:0]     rem_ff [FRAC_BITS];
   logic [DIV_W-1:0]     den_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_ff [FRAC_BITS];
   logic [DIV_W-1:0]     rem_in [FRAC_BITS];
   logic [FRAC_BITS-1:0] quo_in [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic [DIV_W-1:0]     rem_prev;
      logic [DIV_W-1:0]     den_prev;
      logic [FRAC_BITS-1:0] quo_prev;
      logic [DIV_W-1:0]     dbl;
      logic                 ge;

      if (k == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // shift remainder, subtract when it reaches the divisor
      assign dbl       = {rem_prev[DIV_W-2:0], 1'b0};
      assign ge        = dbl >= den_prev;
      assign rem_in[k] = ge ? dbl - den_prev : dbl;
      assign quo_in[k] = {quo_prev[FRAC_BITS-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo_out = quo_ff[FRAC_BITS-1];

endmodule

/* sv/edge_edge_closest_point_classify_top.sv */
// channel  | ports                        | direction
// req      | req_valid/req_stall + p0..p3 | in, one edge pair per transfer
// rsp      | rsp_valid/rsp_stall + result | out, one result per transfer
// csr      | csr_write/csr_wdata          | in, parallel tolerance register
//
// one pair enters per cycle unless a result waits under rsp_stall; the stages are:
// eight arithmetic stages, one divider stage per fraction bit, one output register
// the whole pipeline advances together; it holds while a result waits under rsp_stall
// synchronous active-high reset clears valid bits and loads the tolerance with 1
// depends on eecpc_pkg and eecpc_div
module edge_edge_closest_point_classify_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [eecpc_pkg::TOL_W-1:0]            csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p0_x,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p0_y,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p0_z,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p1_x,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p1_y,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p1_z,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p2_x,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p2_y,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p2_z,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p3_x,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p3_y,
   input  logic signed [eecpc_pkg::COORD_BITS-1:0] req_p3_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [3:0]                            rsp_pair_class,
   output logic [eecpc_pkg::OUT_W-1:0]            rsp_first_param,
   output logic [eecpc_pkg::OUT_W-1:0]            rsp_second_param
);
   import eecpc_pkg::*;

   logic en;
   logic [TOL_W-1:0] tol_ff;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write) begin
         tol_ff <= csr_wdata;
      end
   end

   // global advance: hold only while a result waits
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: edge vectors
   logic signed [COORD_BITS-1:0] p0 [3], p1 [3], p2 [3], p3 [3];
   logic signed [DIFF_W-1:0]     s1_e0_ff [3], s1_e1_ff [3], s1_x02_ff [3];
   logic signed [DIFF_W-1:0]     s1_e0_in [3], s1_e1_in [3], s1_x02_in [3];

   assign p0 = '{req_p0_x, req_p0_y, req_p0_z};
   assign p1 = '{req_p1_x, req_p1_y, req_p1_z};
   assign p2 = '{req_p2_x, req_p2_y, req_p2_z};
   assign p3 = '{req_p3_x, req_p3_y, req_p3_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_e0_in[i]  = DIFF_W'(p1[i]) - DIFF_W'(p0[i]);
         s1_e1_in[i]  = DIFF_W'(p3[i]) - DIFF_W'(p2[i]);
         s1_x02_in[i] = DIFF_W'(p2[i]) - DIFF_W'(p0[i]);
      end
   end

   // stage 2: component products
   logic signed [PROD_W-1:0] s2_aa_ff [3], s2_bb_ff [3], s2_cc_ff [3];
   logic signed [PROD_W-1:0] s2_dd_ff [3], s2_ee_ff [3];
   logic signed [PROD_W-1:0] s2_aa_in [3], s2_bb_in [3], s2_cc_in [3];
   logic signed [PROD_W-1:0] s2_dd_in [3], s2_ee_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_aa_in[i] = s1_e0_ff[i] * s1_e0_ff[i];
         s2_bb_in[i] = s1_e0_ff[i] * s1_e1_ff[i];
         s2_cc_in[i] = s1_e1_ff[i] * s1_e1_ff[i];
         s2_dd_in[i] = s1_x02_ff[i] * s1_e0_ff[i];
         s2_ee_in[i] = s1_x02_ff[i] * s1_e1_ff[i];
      end
   end

   // stage 3: dot products
   logic signed [DOT_W-1:0] s3_a_ff, s3_b_ff, s3_c_ff, s3_d_ff, s3_e_ff;
   logic signed [DOT_W-1:0] s3_a_in, s3_b_in, s3_c_in, s3_d_in, s3_e_in;

   assign s3_a_in = DOT_W'(s2_aa_ff[0]) + DOT_W'(s2_aa_ff[1]) + DOT_W'(s2_aa_ff[2]);
   assign s3_b_in = -(DOT_W'(s2_bb_ff[0]) + DOT_W'(s2_bb_ff[1]) + DOT_W'(s2_bb_ff[2]));
   assign s3_c_in = DOT_W'(s2_cc_ff[0]) + DOT_W'(s2_cc_ff[1]) + DOT_W'(s2_cc_ff[2]);
   assign s3_d_in = DOT_W'(s2_dd_ff[0]) + DOT_W'(s2_dd_ff[1]) + DOT_W'(s2_dd_ff[2]);
   assign s3_e_in = -(DOT_W'(s2_ee_ff[0]) + DOT_W'(s2_ee_ff[1]) + DOT_W'(s2_ee_ff[2]));

   // stage 4: wide products
   logic signed [BIG_W-1:0] s4_ac_ff, s4_bsq_ff, s4_cd_ff, s4_be_ff, s4_ae_ff, s4_bd_ff;
   logic signed [BIG_W-1:0] s4_ac_in, s4_bsq_in, s4_cd_in, s4_be_in, s4_ae_in, s4_bd_in;
   logic [TA_W-1:0]         s4_tola_ff, s4_tola_in;
   logic signed [DOT_W-1:0] s4_a_ff, s4_b_ff, s4_c_ff, s4_d_ff, s4_e_ff;

   assign s4_ac_in   = s3_a_ff * s3_c_ff;
   assign s4_bsq_in  = s3_b_ff * s3_b_ff;
   assign s4_cd_in   = s3_c_ff * s3_d_ff;
   assign s4_be_in   = s3_b_ff * s3_e_ff;
   assign s4_ae_in   = s3_a_ff * s3_e_ff;
   assign s4_bd_in   = s3_b_ff * s3_d_ff;
   assign s4_tola_in = TA_W'(tol_ff) * TA_W'(s3_a_ff[LEN_W-1:0]);

   // stage 5: determinant, numerators, split tolerance product
   logic signed [DEL_W-1:0]     s5_d0_ff, s5_n0_ff, s5_n1_ff;
   logic signed [DEL_W-1:0]     s5_d0_in, s5_n0_in, s5_n1_in;
   logic [TA_LO+LEN_W-1:0]      s5_plo_ff, s5_plo_in;
   logic [TA_HI+LEN_W-1:0]      s5_phi_ff, s5_phi_in;
   logic signed [DOT_W-1:0]     s5_a_ff, s5_b_ff, s5_c_ff, s5_d_ff, s5_e_ff;

   assign s5_d0_in  = DEL_W'(s4_ac_ff) - DEL_W'(s4_bsq_ff);
   assign s5_n0_in  = DEL_W'(s4_cd_ff) - DEL_W'(s4_be_ff);
   assign s5_n1_in  = DEL_W'(s4_ae_ff) - DEL_W'(s4_bd_ff);
   assign s5_plo_in = (TA_LO+LEN_W)'(s4_tola_ff[TA_LO-1:0])
                      * (TA_LO+LEN_W)'(s4_c_ff[LEN_W-1:0]);
   assign s5_phi_in = (TA_HI+LEN_W)'(s4_tola_ff[TA_W-1:TA_LO])
                      * (TA_HI+LEN_W)'(s4_c_ff[LEN_W-1:0]);

   // stage 6: parallel test and t0 range flags
   logic                    s6_no_ee_ff, s6_n0_le0_ff, s6_half_lt_ff, s6_n0_ge_ff;
   logic                    s6_no_ee_in, s6_n0_le0_in, s6_half_lt_in, s6_n0_ge_in;
   logic [CMP_W-1:0]        s6_lhs, s6_rhs;
   logic signed [DEL_W-1:0] s6_d0_ff, s6_n0_ff, s6_n1_ff;
   logic signed [DOT_W-1:0] s6_a_ff, s6_b_ff, s6_c_ff, s6_d_ff, s6_e_ff;

   assign s6_lhs        = CMP_W'(s5_d0_ff) << TOL_W;
   assign s6_rhs        = (CMP_W'(s5_phi_ff) << TA_LO) + CMP_W'(s5_plo_ff);
   assign s6_no_ee_in   = s6_lhs < s6_rhs;
   assign s6_n0_le0_in  = s5_n0_ff <= 0;
   assign s6_half_lt_in = $signed({s5_n0_ff, 1'b0}) < (DEL_W+1)'(s5_d0_ff);
   assign s6_n0_ge_in   = s5_n0_ff >= s5_d0_ff;

   // stage 7: first branch picks the t1 problem
   pair_class_type          s7_cls_ff, s7_cls_in;
   param_sel_type           s7_t0_sel_ff, s7_t0_sel_in;
   logic signed [DEL_W-1:0] s7_n1s_ff, s7_n1s_in, s7_d1s_ff, s7_d1s_in;
   logic signed [DOT_W:0]   s7_db_ff, s7_db_in;
   logic signed [DEL_W-1:0] s7_d0_ff, s7_n0_ff;
   logic signed [DOT_W-1:0] s7_a_ff, s7_d_ff;

   assign s7_db_in = (DOT_W+1)'(s6_d_ff) - (DOT_W+1)'(s6_b_ff);

   always_comb begin
      if (s6_n0_le0_ff || (s6_no_ee_ff && s6_half_lt_ff)) begin
         s7_cls_in    = CLS_VE023;
         s7_t0_sel_in = SEL_ZERO;
         s7_n1s_in    = DEL_W'(s6_e_ff);
         s7_d1s_in    = DEL_W'(s6_c_ff);
      end else if (s6_n0_ge_ff || s6_no_ee_ff) begin
         s7_cls_in    = CLS_VE123;
         s7_t0_sel_in = SEL_ONE;
         s7_n1s_in    = DEL_W'(s6_e_ff) - DEL_W'(s6_b_ff);
         s7_d1s_in    = DEL_W'(s6_c_ff);
      end else begin
         s7_cls_in    = CLS_EE;
         s7_t0_sel_in = SEL_DIV;
         s7_n1s_in    = s6_n1_ff;
         s7_d1s_in    = s6_d0_ff;
      end
   end

   // stage 8: second branch, divider operands
   meta_type         s8_meta_ff, s8_meta_in;
   logic [DIV_W-1:0] s8_n0_ff, s8_n0_in, s8_dn0_ff, s8_dn0_in;
   logic [DIV_W-1:0] s8_n1_ff, s8_n1_in, s8_dn1_ff, s8_dn1_in;
   logic             s7_valid_ff;

   always_comb begin
      s8_meta_in.valid  = s7_valid_ff;
      s8_meta_in.cls    = s7_cls_ff;
      s8_meta_in.t0_sel = s7_t0_sel_ff;
      s8_meta_in.t1_sel = SEL_DIV;
      s8_n0_in          = DIV_W'(s7_n0_ff);
      s8_dn0_in         = DIV_W'(s7_d0_ff);
      s8_n1_in          = DIV_W'(s7_n1s_ff);
      s8_dn1_in         = DIV_W'(s7_d1s_ff);
      // t1 clamped low: t0 from the start point p2 of edge p2-p3
      if (s7_n1s_ff <= 0) begin
         s8_meta_in.t1_sel = SEL_ZERO;
         s8_n0_in          = DIV_W'(s7_d_ff);
         s8_dn0_in         = DIV_W'(s7_a_ff);
         if (s7_d_ff <= 0) begin
            s8_meta_in.cls    = CLS_VV02;
            s8_meta_in.t0_sel = SEL_ZERO;
         end else if (s7_d_ff >= s7_a_ff) begin
            s8_meta_in.cls    = CLS_VV12;
            s8_meta_in.t0_sel = SEL_ONE;
         end else begin
            s8_meta_in.cls    = CLS_VE201;
            s8_meta_in.t0_sel = SEL_DIV;
         end
      // t1 clamped high: t0 from the end point p3 of edge p2-p3
      end else if (s7_n1s_ff >= s7_d1s_ff) begin
         s8_meta_in.t1_sel = SEL_ONE;
         s8_n0_in          = DIV_W'(s7_db_ff);
         s8_dn0_in         = DIV_W'(s7_a_ff);
         if (s7_db_ff <= 0) begin
            s8_meta_in.cls    = CLS_VV03;
            s8_meta_in.t0_sel = SEL_ZERO;
         end else if (s7_db_ff >= (DOT_W+1)'(s7_a_ff)) begin
            s8_meta_in.cls    = CLS_VV13;
            s8_meta_in.t0_sel = SEL_ONE;
         end else begin
            s8_meta_in.cls    = CLS_VE301;
            s8_meta_in.t0_sel = SEL_DIV;
         end
      end
   end

   // valid bits of the arithmetic stages
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
      end
   end

   // payload of the arithmetic stages
   always_ff @(posedge clock) begin
      if (en) begin
         s1_e0_ff  <= s1_e0_in;
         s1_e1_ff  <= s1_e1_in;
         s1_x02_ff <= s1_x02_in;
         s2_aa_ff  <= s2_aa_in;
         s2_bb_ff  <= s2_bb_in;
         s2_cc_ff  <= s2_cc_in;
         s2_dd_ff  <= s2_dd_in;
         s2_ee_ff  <= s2_ee_in;
         s3_a_ff   <= s3_a_in;
         s3_b_ff   <= s3_b_in;
         s3_c_ff   <= s3_c_in;
         s3_d_ff   <= s3_d_in;
         s3_e_ff   <= s3_e_in;
         s4_ac_ff  <= s4_ac_in;
         s4_bsq_ff <= s4_bsq_in;
         s4_cd_ff  <= s4_cd_in;
         s4_be_ff  <= s4_be_in;
         s4_ae_ff  <= s4_ae_in;
         s4_bd_ff  <= s4_bd_in;
         s4_tola_ff <= s4_tola_in;
         s4_a_ff   <= s3_a_ff;
         s4_b_ff   <= s3_b_ff;
         s4_c_ff   <= s3_c_ff;
         s4_d_ff   <= s3_d_ff;
         s4_e_ff   <= s3_e_ff;
         s5_d0_ff  <= s5_d0_in;
         s5_n0_ff  <= s5_n0_in;
         s5_n1_ff  <= s5_n1_in;
         s5_plo_ff <= s5_plo_in;
         s5_phi_ff <= s5_phi_in;
         s5_a_ff   <= s4_a_ff;
         s5_b_ff   <= s4_b_ff;
         s5_c_ff   <= s4_c_ff;
         s5_d_ff   <= s4_d_ff;
         s5_e_ff   <= s4_e_ff;
         s6_no_ee_ff   <= s6_no_ee_in;
         s6_n0_le0_ff  <= s6_n0_le0_in;
         s6_half_lt_ff <= s6_half_lt_in;
         s6_n0_ge_ff   <= s6_n0_ge_in;
         s6_d0_ff  <= s5_d0_ff;
         s6_n0_ff  <= s5_n0_ff;
         s6_n1_ff  <= s5_n1_ff;
         s6_a_ff   <= s5_a_ff;
         s6_b_ff   <= s5_b_ff;
         s6_c_ff   <= s5_c_ff;
         s6_d_ff   <= s5_d_ff;
         s6_e_ff   <= s5_e_ff;
         s7_cls_ff    <= s7_cls_in;
         s7_t0_sel_ff <= s7_t0_sel_in;
         s7_n1s_ff <= s7_n1s_in;
         s7_d1s_ff <= s7_d1s_in;
         s7_db_ff  <= s7_db_in;
         s7_d0_ff  <= s6_d0_ff;
         s7_n0_ff  <= s6_n0_ff;
         s7_a_ff   <= s6_a_ff;
         s7_d_ff   <= s6_d_ff;
         s8_n0_ff  <= s8_n0_in;
         s8_dn0_ff <= s8_dn0_in;
         s8_n1_ff  <= s8_n1_in;
         s8_dn1_ff <= s8_dn1_in;
      end
   end

   // quotient pipelines for t0 and t1
   logic [FRAC_BITS-1:0] q0, q1;

   eecpc_div u_div_t0 (
      .clock   (clock),
      .en      (en),
      .num_in  (s8_n0_ff),
      .den_in  (s8_dn0_ff),
      .quo_out (q0)
   );

   eecpc_div u_div_t1 (
      .clock   (clock),
      .en      (en),
      .num_in  (s8_n1_ff),
      .den_in  (s8_dn1_ff),
      .quo_out (q1)
   );

   // class and selects ride alongside the dividers
   meta_type dly_meta_ff [FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_meta_ff <= '0;
         for (int k = 0; k < FRAC_BITS; k++) begin
            dly_meta_ff[k] <= '0;
         end
      end else if (en) begin
         s8_meta_ff     <= s8_meta_in;
         dly_meta_ff[0] <= s8_meta_ff;
         for (int k = 1; k < FRAC_BITS; k++) begin
            dly_meta_ff[k] <= dly_meta_ff[k-1];
         end
      end
   end

   // output register
   meta_type         out_meta;
   logic             rsp_valid_ff;
   logic [3:0]       rsp_cls_ff;
   logic [OUT_W-1:0] rsp_t0_ff, rsp_t0_in, rsp_t1_ff, rsp_t1_in;

   assign out_meta = dly_meta_ff[FRAC_BITS-1];

   always_comb begin
      case (out_meta.t0_sel)
         SEL_ZERO: rsp_t0_in = '0;
         SEL_ONE:  rsp_t0_in = PARAM_ONE;
         SEL_DIV:  rsp_t0_in = {1'b0, q0};
         default:  rsp_t0_in = '0;
      endcase
      case (out_meta.t1_sel)
         SEL_ZERO: rsp_t1_in = '0;
         SEL_ONE:  rsp_t1_in = PARAM_ONE;
         SEL_DIV:  rsp_t1_in = {1'b0, q1};
         default:  rsp_t1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= out_meta.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_cls_ff <= out_meta.cls;
         rsp_t0_ff  <= rsp_t0_in;
         rsp_t1_ff  <= rsp_t1_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pair_class   = rsp_cls_ff;
   assign rsp_first_param  = rsp_t0_ff;
   assign rsp_second_param = rsp_t1_ff;

endmodule

/* sv/eecpc_checker.sv */
// port-level checks on the edge pair classifier and the bind that attaches them
// depends on eecpc_pkg and assert_macros.svh
`include "assert_macros.svh"

module eecpc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [3:0]                   rsp_pair_class,
   input logic [eecpc_pkg::OUT_W-1:0]  rsp_first_param,
   input logic [eecpc_pkg::OUT_W-1:0]  rsp_second_param
);
   import eecpc_pkg::*;

   // input side stalls exactly when a result is held back
   `EECPC_ASSERT_ALWAYS(a_stall_link, req_stall == (rsp_valid && rsp_stall), "req stall mismatch")

   // a held result keeps its value
   `EECPC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pair_class) && $stable(rsp_first_param) && $stable(rsp_second_param), "held result changed")

   // class code and parameters stay in range
   `EECPC_ASSERT(a_rsp_range, rsp_valid |-> rsp_pair_class <= CLS_VE301 && rsp_first_param <= PARAM_ONE && rsp_second_param <= PARAM_ONE, "result out of range")

   // the VV02 and VV13 vertex-vertex classes sit on the matching ends
   `EECPC_ASSERT(a_vv_ends, rsp_valid && (rsp_pair_class == CLS_VV02 || rsp_pair_class == CLS_VV13) |-> rsp_first_param == rsp_second_param && (rsp_first_param == '0 || rsp_first_param == PARAM_ONE), "vertex pair not on ends")

endmodule

bind edge_edge_closest_point_classify_top eecpc_checker u_eecpc_checker (.*);
